// File: design/assert_macros.svh
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_ON(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_ON(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: design/hpwq_pkg.sv
// types and constants of the hall pulse width qualifier
package hpwq_pkg;

    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    // result codes
    typedef enum logic [2:0] {
        OUT_ARMED      = 3'd0,
        OUT_GAP_DROP   = 3'd1,
        OUT_ON_ARMED   = 3'd2,
        OUT_OFF_UNARM  = 3'd3,
        OUT_TOO_SHORT  = 3'd4,
        OUT_TOO_LONG   = 3'd5,
        OUT_ACCEPTED   = 3'd6,
        OUT_TAKEN      = 3'd7
    } outcome_t;

    // input operation codes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_GAP    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_WIDTH  = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_WIDTH  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LOW = CFG_INDEX_W'(3);

    // register reset values
    localparam logic [TIME_W-1:0] MIN_GAP_RST    = TIME_W'(5000);
    localparam logic [TIME_W-1:0] MIN_WIDTH_RST  = TIME_W'(2000);
    localparam logic [TIME_W-1:0] MAX_WIDTH_RST  = TIME_W'(2000000);
    localparam logic              ACTIVE_LOW_RST = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

endpackage

// File: design/hpwq_in_if.sv
// edge event / take request channel
interface hpwq_in_if;
    import hpwq_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [TIME_W-1:0] time_us;
    logic              pin_level;

    modport source (output valid, output op, output time_us, output pin_level, input ready);
    modport sink   (input valid, input op, input time_us, input pin_level, output ready);
endinterface

// File: design/hpwq_out_if.sv
// result channel
interface hpwq_out_if;
    import hpwq_pkg::*;

    logic               valid;
    logic               ready;
    outcome_t           outcome;
    logic               timeout_cancel;
    logic [COUNT_W-1:0] pulse_count;
    logic [TIME_W-1:0]  last_width;

    modport source (output valid, output outcome, output timeout_cancel,
                    output pulse_count, output last_width, input ready);
    modport sink   (input valid, input outcome, input timeout_cancel,
                    input pulse_count, input last_width, output ready);
endinterface

// File: design/hpwq_cfg_if.sv
// configuration write channel
interface hpwq_cfg_if;
    import hpwq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/hall_pulse_width_qualifier.sv
// Hall pulse width qualifier: takes one edge event or count take request per cycle while
// it is not stalled and returns one result word for each, through an input register and then
// a result register. The sustained rate, while results are drained, is one word per clock, set
// by the combinational wrapped subtract and compare against the stored arm time and last
// accepted time, which updates the pulse state before the next word is evaluated. The input
// stalls once the result register waits on the consumer and the input register holds a word.
// There is no clearing pass after reset; configuration writes are taken in any cycle.
`include "assert_macros.svh"

module hall_pulse_width_qualifier (
    input  logic      clk,
    input  logic      rst_n,
    hpwq_cfg_if.sink  cfg,
    hpwq_in_if.sink   events,
    hpwq_out_if.source results
);
    import hpwq_pkg::*;

    // configuration registers
    logic [TIME_W-1:0] min_gap_reg;
    logic [TIME_W-1:0] min_width_reg;
    logic [TIME_W-1:0] max_width_reg;
    logic              active_low_reg;

    // pulse state
    logic               armed_reg,       armed_next;
    logic [TIME_W-1:0]  on_time_reg,     on_time_next;
    logic [TIME_W-1:0]  last_accept_reg, last_accept_next;
    logic [COUNT_W-1:0] count_reg,       count_next;
    logic [TIME_W-1:0]  width_reg,       width_next;

    // input register
    logic              in_vld_reg;
    logic              op_reg;
    logic [TIME_W-1:0] time_reg;
    logic              level_reg;

    // result register
    logic               res_vld_reg, res_vld_next;
    outcome_t           res_outcome_reg, outcome_next;
    logic               res_cancel_reg,  cancel_next;
    logic [COUNT_W-1:0] res_count_reg,   reported_next;
    logic [TIME_W-1:0]  res_width_reg;

    logic              fire;
    logic              take_in;
    logic [TIME_W-1:0] since_on;
    logic [TIME_W-1:0] since_accept;
    logic              stale;
    logic              armed_eff;
    logic              is_active;

    // handshake and pipeline advance
    assign fire    = in_vld_reg && (!res_vld_reg || results.ready);
    assign take_in = !in_vld_reg || fire;
    assign res_vld_next = fire || (res_vld_reg && !results.ready);

    assign events.ready = take_in;
    assign cfg.ready    = 1'b1;

    assign results.valid          = res_vld_reg;
    assign results.outcome        = res_outcome_reg;
    assign results.timeout_cancel = res_cancel_reg;
    assign results.pulse_count    = res_count_reg;
    assign results.last_width     = res_width_reg;

    // wrapped time differences and stale arm check
    assign since_on     = time_reg - on_time_reg;
    assign since_accept = time_reg - last_accept_reg;
    assign stale        = armed_reg && (since_on > max_width_reg);
    assign armed_eff    = armed_reg && !stale;
    assign is_active    = (level_reg == !active_low_reg);

    // classify the word and work out the next pulse state
    always_comb
    begin
        armed_next       = armed_reg;
        on_time_next     = on_time_reg;
        last_accept_next = last_accept_reg;
        count_next       = count_reg;
        width_next       = width_reg;
        cancel_next      = 1'b0;
        outcome_next     = OUT_TAKEN;
        reported_next    = count_reg;
        if (op_reg == OP_TAKE)
        begin
            count_next = '0;
        end
        else
        begin
            cancel_next = stale;
            armed_next  = armed_eff;
            if (is_active)
            begin
                if (since_accept < min_gap_reg)
                    outcome_next = OUT_GAP_DROP;
                else if (armed_eff)
                    outcome_next = OUT_ON_ARMED;
                else
                begin
                    on_time_next = time_reg;
                    armed_next   = 1'b1;
                    outcome_next = OUT_ARMED;
                end
            end
            else if (!armed_eff)
            begin
                outcome_next = OUT_OFF_UNARM;
            end
            else
            begin
                armed_next = 1'b0;
                if (since_on < min_width_reg)
                    outcome_next = OUT_TOO_SHORT;
                else if (since_on > max_width_reg)
                    outcome_next = OUT_TOO_LONG;
                else
                begin
                    if (count_reg != COUNT_MAX)
                        count_next = count_reg + COUNT_W'(1);
                    width_next       = since_on;
                    last_accept_next = time_reg;
                    outcome_next     = OUT_ACCEPTED;
                end
            end
            reported_next = count_next;
        end
    end

    // control, configuration and pulse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg     <= MIN_GAP_RST;
            min_width_reg   <= MIN_WIDTH_RST;
            max_width_reg   <= MAX_WIDTH_RST;
            active_low_reg  <= ACTIVE_LOW_RST;
            armed_reg       <= 1'b0;
            on_time_reg     <= '0;
            last_accept_reg <= '0;
            count_reg       <= '0;
            width_reg       <= '0;
            in_vld_reg      <= 1'b0;
            res_vld_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_MIN_GAP:    min_gap_reg    <= cfg.data[TIME_W-1:0];
                    REG_MIN_WIDTH:  min_width_reg  <= cfg.data[TIME_W-1:0];
                    REG_MAX_WIDTH:  max_width_reg  <= cfg.data[TIME_W-1:0];
                    REG_ACTIVE_LOW: active_low_reg <= cfg.data[0];
                    default:        ;
                endcase
            end
            if (fire)
            begin
                armed_reg       <= armed_next;
                on_time_reg     <= on_time_next;
                last_accept_reg <= last_accept_next;
                count_reg       <= count_next;
                width_reg       <= width_next;
            end
            if (take_in)
                in_vld_reg <= events.valid;
            res_vld_reg <= res_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_in && events.valid)
        begin
            op_reg    <= events.op;
            time_reg  <= events.time_us;
            level_reg <= events.pin_level;
        end
        if (fire)
        begin
            res_outcome_reg <= outcome_next;
            res_cancel_reg  <= cancel_next;
            res_count_reg   <= reported_next;
            res_width_reg   <= width_next;
        end
    end

    // checks on the pulse state logic
    `ASSERT_ON(a_take_clears, fire && (op_reg == OP_TAKE) |=> count_reg == '0, "count not cleared by take")
    `ASSERT_ON(a_arm_sets, fire && (outcome_next == OUT_ARMED) |=> armed_reg, "arm edge did not arm")
    `ASSERT_ON(a_take_no_cancel, res_vld_reg && (res_outcome_reg == OUT_TAKEN) |-> !res_cancel_reg, "cancel flagged on take")
    `ASSERT_ON(a_hold_input, in_vld_reg && !fire |=> in_vld_reg && $stable(time_reg) && $stable(op_reg), "held input word changed")
    `ASSERT_NEVER(a_no_too_long, res_vld_reg && (res_outcome_reg == OUT_TOO_LONG), "too long reported after stale check")

endmodule

// File: sim/hall_pulse_width_qualifier_tb.sv
// testbench for the hall pulse width qualifier: directed and random edge words checked against a predictor
`timescale 1ns / 100ps

module hall_pulse_width_qualifier_tb;
    import hpwq_pkg::*;

    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTING_WORDS = 110;
    localparam int unsigned BURST_PULSES  = 60;

    // expected fields of one result word
    typedef struct packed {
        outcome_t           outcome;
        logic               cancel;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  width;
    } pulse_result_t;

    logic clk;
    logic rst_n;

    hpwq_cfg_if cfg_bus ();
    hpwq_in_if  ev_bus ();
    hpwq_out_if res_bus ();

    hall_pulse_width_qualifier dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .events  (ev_bus),
        .results (res_bus)
    );

    // predictor copy of registers and pulse state
    logic [TIME_W-1:0]  min_gap_cfg;
    logic [TIME_W-1:0]  min_width_cfg;
    logic [TIME_W-1:0]  max_width_cfg;
    logic               active_low_cfg;
    logic               armed_q;
    logic [TIME_W-1:0]  on_time_q;
    logic [TIME_W-1:0]  last_accept_q;
    logic [COUNT_W-1:0] pulse_cnt;
    logic [TIME_W-1:0]  width_seen_q;

    pulse_result_t     pending_results[$];
    int unsigned       mismatches;
    int unsigned       quiet_cycles;
    logic [TIME_W-1:0] stamp_us;
    bit                idle_on;
    bit                hold_start;
    int unsigned       hold_left;

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // pulse qualification as the block should do it
    function automatic pulse_result_t qualify_event(input logic op,
                                                    input logic [TIME_W-1:0] now,
                                                    input logic lvl);
        pulse_result_t     r;
        logic [TIME_W-1:0] span;
        r.cancel = 1'b0;
        if (op == OP_TAKE) begin
            r.outcome = OUT_TAKEN;
            r.count   = pulse_cnt;
            pulse_cnt = '0;
        end
        else begin
            span = now - on_time_q;
            if (armed_q && span > max_width_cfg) begin
                armed_q  = 1'b0;
                r.cancel = 1'b1;
            end
            if (lvl == ~active_low_cfg) begin
                span = now - last_accept_q;
                if (span < min_gap_cfg)
                    r.outcome = OUT_GAP_DROP;
                else if (armed_q)
                    r.outcome = OUT_ON_ARMED;
                else begin
                    on_time_q = now;
                    armed_q   = 1'b1;
                    r.outcome = OUT_ARMED;
                end
            end
            else if (!armed_q)
                r.outcome = OUT_OFF_UNARM;
            else begin
                span    = now - on_time_q;
                armed_q = 1'b0;
                if (span < min_width_cfg)
                    r.outcome = OUT_TOO_SHORT;
                else if (span > max_width_cfg)
                    r.outcome = OUT_TOO_LONG;
                else begin
                    if (pulse_cnt != COUNT_MAX)
                        pulse_cnt = pulse_cnt + 1'b1;
                    width_seen_q  = span;
                    last_accept_q = now;
                    r.outcome     = OUT_ACCEPTED;
                end
            end
            r.count = pulse_cnt;
        end
        r.width = width_seen_q;
        return r;
    endfunction

    // span near a bound, up to twice it, or anywhere
    function automatic logic [TIME_W-1:0] pick_span(input logic [TIME_W-1:0] bound);
        int unsigned r;
        logic [63:0] wide;
        r = $urandom_range(0, 99);
        if (r < 45)
            return bound + TIME_W'($urandom_range(0, 2)) - 1'b1;
        if (r < 92) begin
            wide = {$urandom, $urandom} % ({32'd0, bound} * 2 + 1);
            return wide[TIME_W-1:0];
        end
        return TIME_W'($urandom);
    endfunction

    // send one word, with random idle cycles ahead of it while idling is on
    task automatic send_word(input logic op, input logic [TIME_W-1:0] stamp, input logic lvl);
        while (idle_on && $urandom_range(0, 99) < 31) begin
            ev_bus.valid <= 1'b0;
            @(negedge clk);
        end
        ev_bus.valid     <= 1'b1;
        ev_bus.op        <= op;
        ev_bus.time_us   <= stamp;
        ev_bus.pin_level <= lvl;
        do @(posedge clk); while (!ev_bus.ready);
        pending_results.push_back(qualify_event(op, stamp, lvl));
        @(negedge clk);
    endtask

    // advance the timestamp and send an active or release edge
    task automatic send_edge(input logic [TIME_W-1:0] delta, input logic active);
        stamp_us += delta;
        send_word(OP_EDGE, stamp_us, active ? ~active_low_cfg : active_low_cfg);
    endtask

    task automatic send_take();
        send_word(OP_TAKE, TIME_W'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // stop sending and let every expected word arrive
    task automatic wait_idle();
        ev_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            REG_MIN_GAP:    min_gap_cfg    = value;
            REG_MIN_WIDTH:  min_width_cfg  = value;
            REG_MAX_WIDTH:  max_width_cfg  = value;
            REG_ACTIVE_LOW: active_low_cfg = value[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // all registers, then a write to an unused index that must be ignored
    task automatic apply_settings(input logic [TIME_W-1:0] gap, input logic [TIME_W-1:0] min_w,
                                  input logic [TIME_W-1:0] max_w, input logic act_low);
        wait_idle();
        write_reg(REG_MIN_GAP, gap);
        write_reg(REG_MIN_WIDTH, min_w);
        write_reg(REG_MAX_WIDTH, max_w);
        write_reg(REG_ACTIVE_LOW, CFG_DATA_W'(act_low));
        write_reg(CFG_INDEX_W'($urandom_range(REG_ACTIVE_LOW + 1, 2**CFG_INDEX_W - 1)),
                  CFG_DATA_W'($urandom));
        cfg_bus.valid <= 1'b0;
    endtask

    // mixed stream: mostly well-formed pulses, some takes, stale arms and noise
    task automatic run_random_words(input int unsigned n_words);
        int unsigned sent;
        int unsigned r;
        sent = 0;
        while (sent < n_words) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                send_edge(pick_span(min_gap_cfg), 1'b1);
                send_edge(pick_span(r < 40 ? min_width_cfg : max_width_cfg), 1'b0);
                sent += 2;
            end
            else if (r < 75) begin
                send_take();
                sent++;
            end
            else if (r < 88) begin
                send_edge(pick_span(max_width_cfg), 1'($urandom_range(0, 1)));
                sent++;
            end
            else begin
                stamp_us = TIME_W'($urandom);
                send_word(OP_EDGE, stamp_us, 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // reset values: early first edge, every edge outcome but too long, stale cancel, take, wrap
    task automatic test_reset_defaults();
        send_word(OP_EDGE, 32'd100, 1'b0);
        send_word(OP_EDGE, 32'd6000, 1'b1);
        send_word(OP_EDGE, 32'd6000, 1'b0);
        send_word(OP_EDGE, 32'd6500, 1'b0);
        send_word(OP_EDGE, 32'd7999, 1'b1);
        send_word(OP_EDGE, 32'd10000, 1'b0);
        send_word(OP_EDGE, 32'd12000, 1'b1);
        send_word(OP_EDGE, 32'd16999, 1'b0);
        send_word(OP_EDGE, 32'd17000, 1'b0);
        send_word(OP_EDGE, 32'd2017001, 1'b1);
        send_word(OP_EDGE, 32'd2100000, 1'b0);
        send_take();
        send_word(OP_EDGE, 32'd4100000, 1'b1);
        send_take();
        send_take();
        send_word(OP_EDGE, 32'hFFFF_FF00, 1'b0);
        send_word(OP_EDGE, 32'h0000_0800, 1'b1);
        send_word(OP_TAKE, 32'hFFFF_FFFF, 1'b1);
    endtask

    // active high pin and register extremes; over-long width is cancelled first
    task automatic test_polarity_extremes();
        apply_settings(32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
        send_word(OP_EDGE, 32'd0, 1'b1);
        send_word(OP_EDGE, 32'd0, 1'b0);
        send_word(OP_EDGE, 32'hFFFF_FFFF, 1'b1);
        send_word(OP_EDGE, 32'hFFFF_FFFE, 1'b0);
        send_word(OP_TAKE, 32'd0, 1'b0);
        apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1);
        send_word(OP_EDGE, 32'hFFFF_FFFD, 1'b0);
        send_word(OP_EDGE, 32'hFFFF_FFFE, 1'b0);
        apply_settings(32'd0, 32'd0, 32'd0, 1'b1);
        send_word(OP_EDGE, 32'd5, 1'b0);
        send_word(OP_EDGE, 32'd6, 1'b1);
        send_word(OP_EDGE, 32'd7, 1'b0);
        send_word(OP_EDGE, 32'd7, 1'b1);
    endtask

    // random words under several register settings
    task automatic test_random_settings();
        logic [TIME_W-1:0] min_w;
        apply_settings(MIN_GAP_RST, MIN_WIDTH_RST, MAX_WIDTH_RST, ACTIVE_LOW_RST);
        run_random_words(SETTING_WORDS);
        apply_settings(32'd20, 32'd5, 32'd40, 1'b0);
        run_random_words(SETTING_WORDS);
        apply_settings(32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1);
        run_random_words(SETTING_WORDS);
        apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0);
        run_random_words(SETTING_WORDS);
        apply_settings(32'd3000, 32'd1000, 32'd1000, 1'b1);
        run_random_words(SETTING_WORDS);
        min_w = TIME_W'($urandom_range(0, 200));
        apply_settings(TIME_W'($urandom_range(0, 400)), min_w,
                       min_w + TIME_W'($urandom_range(0, 300)), 1'($urandom_range(0, 1)));
        run_random_words(SETTING_WORDS);
    endtask

    // results held off long enough that the block fills and stalls its input
    task automatic test_result_holdoff();
        apply_settings(32'd20, 32'd5, 32'd40, 1'b0);
        hold_start = 1'b1;
        run_random_words(80);
    endtask

    // back to back accepted pulses with no idling on either side
    task automatic test_no_idle_burst();
        int unsigned n;
        apply_settings(32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1);
        idle_on = 1'b0;
        send_take();
        for (n = 0; n < BURST_PULSES; n++) begin
            send_edge(TIME_W'($urandom_range(0, 50)), 1'b1);
            send_edge(TIME_W'($urandom_range(0, 50)), 1'b0);
        end
        send_take();
        send_take();
        idle_on = 1'b1;
    endtask

    // field compare against the oldest expectation
    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk) begin
        pulse_result_t want;
        if (rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word, expected none, actual outcome %0d",
                         $time, res_bus.outcome);
            end
            else begin
                want = pending_results.pop_front();
                if (res_bus.outcome !== want.outcome)
                    report_field("outcome", 32'(want.outcome), 32'(res_bus.outcome));
                if (res_bus.timeout_cancel !== want.cancel)
                    report_field("timeout_cancel", 32'(want.cancel), 32'(res_bus.timeout_cancel));
                if (res_bus.pulse_count !== want.count)
                    report_field("pulse_count", 32'(want.count), 32'(res_bus.pulse_count));
                if (res_bus.last_width !== want.width)
                    report_field("last_width", want.width, res_bus.last_width);
            end
        end
    end

    // result ready: random stalls, long hold-off on request
    always @(negedge clk) begin
        if (hold_start) begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_bus.ready <= 1'b0;
        end
        else if (idle_on)
            res_bus.ready <= ($urandom_range(0, 99) >= 31);
        else
            res_bus.ready <= 1'b1;
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge clk) begin
        if ((ev_bus.valid && ev_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        rst_n            = 1'b0;
        ev_bus.valid     = 1'b0;
        ev_bus.op        = OP_EDGE;
        ev_bus.time_us   = '0;
        ev_bus.pin_level = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = REG_MIN_GAP;
        cfg_bus.data     = '0;
        res_bus.ready    = 1'b0;
        mismatches       = 0;
        quiet_cycles     = 0;
        idle_on          = 1'b1;
        hold_start       = 1'b0;
        hold_left        = 0;
        stamp_us         = '0;
        min_gap_cfg      = MIN_GAP_RST;
        min_width_cfg    = MIN_WIDTH_RST;
        max_width_cfg    = MAX_WIDTH_RST;
        active_low_cfg   = ACTIVE_LOW_RST;
        armed_q          = 1'b0;
        on_time_q        = '0;
        last_accept_q    = '0;
        pulse_cnt        = '0;
        width_seen_q     = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_polarity_extremes();
        test_random_settings();
        test_result_holdoff();
        test_no_idle_burst();

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
